// ===== hdl/wavh_pkg.sv =====
`default_nettype none

package wavh_pkg;

	// Byte offsets within the canonical header
	localparam int POS_W = 6;
	localparam logic [POS_W-1:0] IDLE_POS = 6'd44;
	localparam logic [POS_W-1:0] LAST_POS = 6'd43;

	localparam logic [POS_W-1:0] OFS_RIFF_TAG  = 6'd0;
	localparam logic [POS_W-1:0] OFS_RIFF_SIZE = 6'd4;
	localparam logic [POS_W-1:0] OFS_WAVE_TAG  = 6'd8;
	localparam logic [POS_W-1:0] OFS_FMT_TAG   = 6'd12;
	localparam logic [POS_W-1:0] OFS_FMT_SIZE  = 6'd16;
	localparam logic [POS_W-1:0] OFS_FORMAT    = 6'd20;
	localparam logic [POS_W-1:0] OFS_CHANNELS  = 6'd22;
	localparam logic [POS_W-1:0] OFS_RATE      = 6'd24;
	localparam logic [POS_W-1:0] OFS_BYTE_RATE = 6'd28;
	localparam logic [POS_W-1:0] OFS_ALIGN     = 6'd32;
	localparam logic [POS_W-1:0] OFS_BITS      = 6'd34;
	localparam logic [POS_W-1:0] OFS_DATA_TAG  = 6'd36;
	localparam logic [POS_W-1:0] OFS_DATA_SIZE = 6'd40;

	// Tag slots in the mismatch vector
	localparam int NUM_TAGS = 4;
	localparam logic [1:0] TAG_RIFF = 2'd0;
	localparam logic [1:0] TAG_WAVE = 2'd1;
	localparam logic [1:0] TAG_FMT  = 2'd2;
	localparam logic [1:0] TAG_DATA = 2'd3;

	// "RIFF", "WAVE", "fmt ", "data"
	localparam logic [7:0] TAG_CHARS [16] = '{
		8'h52, 8'h49, 8'h46, 8'h46,
		8'h57, 8'h41, 8'h56, 8'h45,
		8'h66, 8'h6d, 8'h74, 8'h20,
		8'h64, 8'h61, 8'h74, 8'h61
	};

	// Expected field values
	localparam logic [31:0] FMT_SIZE_PCM = 32'd16;
	localparam logic [15:0] FORMAT_PCM   = 16'd1;
	localparam logic [31:0] RIFF_BIAS    = 32'd36;
	localparam logic [15:0] BITS_8       = 16'd8;
	localparam logic [15:0] BITS_16      = 16'd16;
	localparam logic [15:0] CHANNELS_1   = 16'd1;
	localparam logic [15:0] CHANNELS_2   = 16'd2;
	localparam logic [15:0] ALIGN_1      = 16'd1;
	localparam logic [15:0] ALIGN_2      = 16'd2;
	localparam logic [15:0] ALIGN_4      = 16'd4;

	// Check slots, in reporting order
	localparam int NUM_CHK = 12;
	localparam int CHK_RIFF_TAG  = 0;
	localparam int CHK_WAVE_TAG  = 1;
	localparam int CHK_FMT_TAG   = 2;
	localparam int CHK_FMT_SIZE  = 3;
	localparam int CHK_FORMAT    = 4;
	localparam int CHK_CHANNELS  = 5;
	localparam int CHK_BYTE_RATE = 6;
	localparam int CHK_DATA_TAG  = 7;
	localparam int CHK_RIFF_SIZE = 8;
	localparam int CHK_ALIGN     = 9;
	localparam int CHK_BITS      = 10;
	localparam int CHK_LENGTH    = 11;

	// Error codes
	localparam logic [3:0] ERR_OK        = 4'd0;
	localparam logic [3:0] ERR_RIFF_TAG  = 4'd1;
	localparam logic [3:0] ERR_WAVE_TAG  = 4'd2;
	localparam logic [3:0] ERR_FMT_TAG   = 4'd3;
	localparam logic [3:0] ERR_FMT_SIZE  = 4'd4;
	localparam logic [3:0] ERR_FORMAT    = 4'd5;
	localparam logic [3:0] ERR_CHANNELS  = 4'd6;
	localparam logic [3:0] ERR_BYTE_RATE = 4'd7;
	localparam logic [3:0] ERR_DATA_TAG  = 4'd8;
	localparam logic [3:0] ERR_RIFF_SIZE = 4'd9;
	localparam logic [3:0] ERR_ALIGN     = 4'd10;
	localparam logic [3:0] ERR_BITS      = 4'd11;
	localparam logic [3:0] ERR_LENGTH    = 4'd12;

	// Gathered header fields
	typedef struct packed {
		logic [NUM_TAGS-1:0] tag_mismatch;
		logic [31:0] riff_size;
		logic [31:0] fmt_size;
		logic [15:0] format_tag;
		logic [15:0] channels;
		logic [31:0] rate;
		logic [31:0] byte_rate;
		logic [15:0] align;
		logic [15:0] bits;
		logic [31:0] data_size;
	} wavh_fields_t;

	// Tag lookup result for one offset
	typedef struct packed {
		logic hit;
		logic [1:0] idx;
		logic [7:0] chr;
	} wavh_tag_t;

	function automatic wavh_tag_t tag_expect(input logic [POS_W-1:0] pos);
		wavh_tag_t t;
		t.hit = 1'b1;
		t.idx = TAG_RIFF;
		case (pos) inside
			[OFS_RIFF_TAG : OFS_RIFF_TAG + 6'd3]: t.idx = TAG_RIFF;
			[OFS_WAVE_TAG : OFS_WAVE_TAG + 6'd3]: t.idx = TAG_WAVE;
			[OFS_FMT_TAG : OFS_FMT_TAG + 6'd3]:   t.idx = TAG_FMT;
			[OFS_DATA_TAG : OFS_DATA_TAG + 6'd3]: t.idx = TAG_DATA;
			default: t.hit = 1'b0;
		endcase
		// every tag starts on a four-byte boundary
		t.chr = TAG_CHARS[{t.idx, pos[1:0]}];
		return t;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/wavh_if.sv =====
`default_nettype none

// Header byte channel
interface wavh_in_if;
	logic valid;
	logic ready;
	logic [7:0] data_byte;
	logic start_req;

	modport source (output valid, output data_byte, output start_req, input ready);
	modport sink (input valid, input data_byte, input start_req, output ready);
endinterface

// Result channel
interface wavh_out_if;
	logic valid;
	logic ready;
	logic valid_res;
	logic [3:0] error_code;
	logic [15:0] channel_count;
	logic [15:0] bits_per_sample;
	logic [31:0] sample_rate;
	logic [15:0] block_align;
	logic [31:0] data_length;

	modport source (
		output valid, output valid_res, output error_code, output channel_count,
		output bits_per_sample, output sample_rate, output block_align,
		output data_length, input ready
	);
	modport sink (
		input valid, input valid_res, input error_code, input channel_count,
		input bits_per_sample, input sample_rate, input block_align,
		input data_length, output ready
	);
endinterface

`default_nettype wire

// ===== hdl/wavh_capture.sv =====
`default_nettype none

module wavh_capture
	import wavh_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic adv,
	input  logic take,
	input  logic [7:0] data_byte,
	input  logic start_req,
	output wavh_fields_t fields,
	output logic done,
	output logic [POS_W-1:0] pos
);

	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] pos_cur;
	logic live;
	wavh_tag_t exp_tag;
	logic [NUM_TAGS-1:0] tag_nxt;
	wavh_fields_t f_q;
	logic done_q;

	// Work out the offset of this item and its tag comparison
	always_comb begin
		pos_cur = start_req ? '0 : pos_q;
		live = take && (pos_cur < IDLE_POS);
		exp_tag = tag_expect(pos_cur);
		tag_nxt = start_req ? '0 : f_q.tag_mismatch;
		if (live && exp_tag.hit && (exp_tag.chr != data_byte)) begin
			tag_nxt[exp_tag.idx] = 1'b1;
		end
	end

	// Advance the offset; park at idle after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= IDLE_POS;
			done_q <= 1'b0;
		end else begin
			if (take) begin
				if (live) begin
					pos_q <= (pos_cur == LAST_POS) ? IDLE_POS : pos_cur + 6'd1;
				end else begin
					pos_q <= pos_cur;
				end
			end
			if (adv) begin
				done_q <= live && (pos_cur == LAST_POS);
			end
		end
	end

	// Drop each byte into its field lane
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			f_q <= '0;
		end else if (take) begin
			f_q.tag_mismatch <= tag_nxt;
			if (live) begin
				case (pos_cur) inside
					[OFS_RIFF_SIZE : OFS_RIFF_SIZE + 6'd3]:
						f_q.riff_size[pos_cur[1:0]*8 +: 8] <= data_byte;
					[OFS_FMT_SIZE : OFS_FMT_SIZE + 6'd3]:
						f_q.fmt_size[pos_cur[1:0]*8 +: 8] <= data_byte;
					[OFS_FORMAT : OFS_FORMAT + 6'd1]:
						f_q.format_tag[pos_cur[0]*8 +: 8] <= data_byte;
					[OFS_CHANNELS : OFS_CHANNELS + 6'd1]:
						f_q.channels[pos_cur[0]*8 +: 8] <= data_byte;
					[OFS_RATE : OFS_RATE + 6'd3]:
						f_q.rate[pos_cur[1:0]*8 +: 8] <= data_byte;
					[OFS_BYTE_RATE : OFS_BYTE_RATE + 6'd3]:
						f_q.byte_rate[pos_cur[1:0]*8 +: 8] <= data_byte;
					[OFS_ALIGN : OFS_ALIGN + 6'd1]:
						f_q.align[pos_cur[0]*8 +: 8] <= data_byte;
					[OFS_BITS : OFS_BITS + 6'd1]:
						f_q.bits[pos_cur[0]*8 +: 8] <= data_byte;
					[OFS_DATA_SIZE : OFS_DATA_SIZE + 6'd3]:
						f_q.data_size[pos_cur[1:0]*8 +: 8] <= data_byte;
					default: ;
				endcase
			end
		end
	end

	assign fields = f_q;
	assign done = done_q;
	assign pos = pos_q;

endmodule

`default_nettype wire

// ===== hdl/wavh_check.sv =====
`default_nettype none

module wavh_check
	import wavh_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic adv,
	input  logic done,
	input  wavh_fields_t fields,
	wavh_out_if.source res
);

	logic [31:0] rate_prod;
	logic [31:0] frame_prod;
	logic [31:0] align_bits;
	logic len_fail;
	logic [NUM_CHK-1:0] fail;

	logic vld_s2;
	logic [NUM_CHK-1:0] fail_s2;
	logic [15:0] channels_s2;
	logic [15:0] bits_s2;
	logic [31:0] rate_s2;
	logic [15:0] align_s2;
	logic [31:0] data_s2;
	logic [3:0] err;

	// Evaluate every check on the finished fields
	always_comb begin
		rate_prod = fields.rate * {16'd0, fields.align};
		frame_prod = {16'd0, fields.bits} * {16'd0, fields.channels};
		align_bits = {13'd0, fields.align, 3'd0};
		// an align other than 1, 2 or 4 always fails the length check
		case (fields.align)
			ALIGN_1: len_fail = 1'b0;
			ALIGN_2: len_fail = fields.data_size[0];
			ALIGN_4: len_fail = |fields.data_size[1:0];
			default: len_fail = 1'b1;
		endcase
		fail = '0;
		fail[CHK_RIFF_TAG]  = fields.tag_mismatch[TAG_RIFF];
		fail[CHK_WAVE_TAG]  = fields.tag_mismatch[TAG_WAVE];
		fail[CHK_FMT_TAG]   = fields.tag_mismatch[TAG_FMT];
		fail[CHK_FMT_SIZE]  = fields.fmt_size != FMT_SIZE_PCM;
		fail[CHK_FORMAT]    = fields.format_tag != FORMAT_PCM;
		fail[CHK_CHANNELS]  = (fields.channels != CHANNELS_1) &&
			(fields.channels != CHANNELS_2);
		fail[CHK_BYTE_RATE] = fields.byte_rate != rate_prod;
		fail[CHK_DATA_TAG]  = fields.tag_mismatch[TAG_DATA];
		fail[CHK_RIFF_SIZE] = fields.riff_size != (fields.data_size + RIFF_BIAS);
		fail[CHK_ALIGN]     = align_bits != frame_prod;
		fail[CHK_BITS]      = (fields.bits != BITS_8) && (fields.bits != BITS_16);
		fail[CHK_LENGTH]    = len_fail;
	end

	// Hold the check vector and reported fields
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= done;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fail_s2 <= fail;
			channels_s2 <= fields.channels;
			bits_s2 <= fields.bits;
			rate_s2 <= fields.rate;
			align_s2 <= fields.align;
			data_s2 <= fields.data_size;
		end
	end

	// Pick the first failing check
	always_comb begin
		if (fail_s2[CHK_RIFF_TAG])       err = ERR_RIFF_TAG;
		else if (fail_s2[CHK_WAVE_TAG])  err = ERR_WAVE_TAG;
		else if (fail_s2[CHK_FMT_TAG])   err = ERR_FMT_TAG;
		else if (fail_s2[CHK_FMT_SIZE])  err = ERR_FMT_SIZE;
		else if (fail_s2[CHK_FORMAT])    err = ERR_FORMAT;
		else if (fail_s2[CHK_CHANNELS])  err = ERR_CHANNELS;
		else if (fail_s2[CHK_BYTE_RATE]) err = ERR_BYTE_RATE;
		else if (fail_s2[CHK_DATA_TAG])  err = ERR_DATA_TAG;
		else if (fail_s2[CHK_RIFF_SIZE]) err = ERR_RIFF_SIZE;
		else if (fail_s2[CHK_ALIGN])     err = ERR_ALIGN;
		else if (fail_s2[CHK_BITS])      err = ERR_BITS;
		else if (fail_s2[CHK_LENGTH])    err = ERR_LENGTH;
		else                             err = ERR_OK;
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res.valid <= 1'b0;
		end else if (adv) begin
			res.valid <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res.valid_res <= (err == ERR_OK);
			res.error_code <= err;
			res.channel_count <= channels_s2;
			res.bits_per_sample <= bits_s2;
			res.sample_rate <= rate_s2;
			res.block_align <= align_s2;
			res.data_length <= data_s2;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/wav_header_validator.sv =====
// Checks a canonical 44-byte RIFF/PCM WAV header that arrives one byte per item,
// with start_req marking offset zero. One byte is taken every clock cycle; the
// field capture registers take each byte as it arrives, so back-to-back headers
// stream without gaps. The byte at offset 43 yields one result item, passing the
// done flag, check stage and result register: a valid flag, the first failing
// check as an error code, and the parsed fields as received. Bytes outside a
// header produce nothing. A stalled result holds the whole pipeline, so input is
// refused only while the result register is full and not being taken.
`default_nettype none

module wav_header_validator
	import wavh_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	wavh_in_if.sink hdr,
	wavh_out_if.source res
);

	logic adv;
	logic take;
	wavh_fields_t fields;
	logic done;
	logic [POS_W-1:0] pos;

	// Advance all stages whenever the result register can move
	assign adv = !res.valid || res.ready;
	assign hdr.ready = adv;
	assign take = hdr.valid && adv;

	wavh_capture u_capture (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.take      (take),
		.data_byte (hdr.data_byte),
		.start_req (hdr.start_req),
		.fields    (fields),
		.done      (done),
		.pos       (pos)
	);

	wavh_check u_check (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.done   (done),
		.fields (fields),
		.res    (res)
	);

`ifndef ASSERT_OFF
	ast_valid_matches_code: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (res.valid_res == (res.error_code == ERR_OK)))
		else $error("valid flag disagrees with error code");

	ast_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (res.error_code <= ERR_LENGTH))
		else $error("error code out of range");

	ast_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos <= IDLE_POS)
		else $error("byte offset beyond idle");

	ast_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		(done && adv) |=> !done)
		else $error("header completion seen twice");
`endif

endmodule

`default_nettype wire
